// File: rtl/wam_pkg.sv
package wam_pkg;

  localparam int SAMPLE_W  = 20;
  localparam int LEVEL_W   = 17;
  localparam int IDX_W     = 24;
  localparam int ABS_W     = 41;
  localparam int SQ_W      = 57;
  localparam int TIME_W    = 32;
  localparam int RATE_W    = 18;
  localparam int CH_W      = 4;
  localparam int BUF_W     = 25;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  localparam int FRAC_BITS = 16;
  localparam int TIME_FRAC = 16;

  localparam logic [BUF_W-1:0]    MAX_SAMPLES = BUF_W'(16777216);
  localparam logic [SAMPLE_W-1:0] LEVEL_LIMIT = SAMPLE_W'((1001 << FRAC_BITS) / 1000);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
  localparam logic [CH_W-1:0]   CH_RESET   = CH_W'(2);

  localparam int SCALE_W = RATE_W + CH_W;
  localparam int PROD_W  = TIME_W - 1 + SCALE_W;
  localparam int RIDX_W  = PROD_W + 1 - TIME_FRAC;

  localparam int ROOT_STEPS = (SQ_W + 1) / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int RAD_W      = 2 * ROOT_STEPS;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int STEP_W     = $clog2(SQ_W + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SAMPLE_RATE    = 3'd0,
    REG_CHANNEL_COUNT  = 3'd1,
    REG_BUFFER_SAMPLES = 3'd2,
    REG_START_TIME     = 3'd3,
    REG_END_TIME       = 3'd4
  } reg_index_e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_SCALE,
    W_MUL,
    W_ROUND,
    W_MOD,
    W_CLAMP,
    W_FINISH
  } win_state_e;

  typedef enum logic [2:0] {
    B_ACC,
    B_MEAN,
    B_SQDIV,
    B_ROOT,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic             busy;
    logic             empty;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] stop;
  } window_t;

  typedef struct packed {
    logic               hit;
    logic               last;
    logic [LEVEL_W-1:0] level;
  } beat_t;

endpackage

// File: rtl/wam_window.sv
module wam_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wam_pkg::RATE_W-1:0]   sample_rate_i,
  input  logic [wam_pkg::CH_W-1:0]     channel_count_i,
  input  logic [wam_pkg::BUF_W-1:0]    buffer_samples_i,
  input  logic [wam_pkg::TIME_W-1:0]   start_time_i,
  input  logic [wam_pkg::TIME_W-1:0]   end_time_i,
  output wam_pkg::window_t             win_o
);
  import wam_pkg::*;

  win_state_e          state_q, state_d;
  logic                sel_q, sel_d;
  logic [SCALE_W-1:0]  scale_q;
  logic [PROD_W-1:0]   prod_q;
  logic [RIDX_W-1:0]   ridx_q;
  logic [RIDX_W-1:0]   shr_q;
  logic [CH_W-1:0]     rem_q;
  logic [STEP_W-1:0]   step_q;
  logic [IDX_W-1:0]    first_q, stop_q;
  logic                empty_q;

  logic [TIME_W-1:0]   t_sel;
  logic                t_pos;
  logic [BUF_W-1:0]    count;
  logic [IDX_W-1:0]    count_m1;
  logic                degenerate;
  logic [PROD_W:0]     rounded;
  logic [CH_W:0]       rem_try;
  logic [CH_W:0]       rem_sub;
  logic [CH_W-1:0]     rem_next;
  logic [RIDX_W-1:0]   aligned;
  logic [IDX_W-1:0]    idx;

  always_comb begin
    t_sel      = sel_q ? end_time_i : start_time_i;
    t_pos      = !t_sel[TIME_W-1] && (t_sel != '0);
    count      = (buffer_samples_i > MAX_SAMPLES) ? MAX_SAMPLES : buffer_samples_i;
    count_m1   = IDX_W'(count - BUF_W'(1));
    degenerate = (count == '0) || ($signed(end_time_i) <= $signed(start_time_i));
    rounded    = {1'b0, prod_q} + ((PROD_W + 1)'(1) << (TIME_FRAC - 1));
    rem_try    = {rem_q, shr_q[RIDX_W-1]};
    rem_sub    = rem_try - {1'b0, channel_count_i};
    rem_next   = (rem_try >= {1'b0, channel_count_i}) ? rem_sub[CH_W-1:0]
                                                      : rem_try[CH_W-1:0];
    aligned    = (channel_count_i == '0) ? ridx_q : ridx_q - RIDX_W'(rem_q);
    if (!t_pos) begin
      idx = '0;
    end else if (aligned > RIDX_W'(count_m1)) begin
      idx = count_m1;
    end else begin
      idx = aligned[IDX_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      W_IDLE:   state_d = W_IDLE;
      W_SCALE:  state_d = W_MUL;
      W_MUL:    state_d = W_ROUND;
      W_ROUND:  state_d = W_MOD;
      W_MOD: begin
        if (step_q == STEP_W'(RIDX_W - 1)) begin
          state_d = W_CLAMP;
        end
      end
      W_CLAMP: begin
        state_d = sel_q ? W_FINISH : W_MUL;
        sel_d   = 1'b1;
      end
      W_FINISH: state_d = W_IDLE;
      default:  state_d = W_IDLE;
    endcase
    if (start_i) begin
      state_d = W_SCALE;
      sel_d   = 1'b0;
    end
  end

  always_comb begin
    win_o.busy  = (state_q != W_IDLE);
    win_o.empty = empty_q;
    win_o.first = first_q;
    win_o.stop  = stop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      sel_q   <= 1'b0;
      first_q <= '0;
      stop_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      if (state_q == W_CLAMP) begin
        if (sel_q) begin
          stop_q <= idx;
        end else begin
          first_q <= idx;
        end
      end
      if (state_q == W_FINISH) begin
        if (degenerate) begin
          first_q <= '0;
          stop_q  <= '0;
          empty_q <= 1'b1;
        end else begin
          empty_q <= (first_q >= stop_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      W_SCALE: scale_q <= SCALE_W'(sample_rate_i) * SCALE_W'(channel_count_i);
      W_MUL:   prod_q  <= PROD_W'(t_sel[TIME_W-2:0]) * PROD_W'(scale_q);
      W_ROUND: begin
        ridx_q <= rounded[PROD_W:TIME_FRAC];
        shr_q  <= rounded[PROD_W:TIME_FRAC];
        rem_q  <= '0;
        step_q <= '0;
      end
      W_MOD: begin
        shr_q  <= shr_q << 1;
        rem_q  <= rem_next;
        step_q <= step_q + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/wam_front.sv
module wam_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wam_pkg::SAMPLE_W-1:0]  sample_value_i,
  input  logic                          last_sample_i,
  input  wam_pkg::window_t              win_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output wam_pkg::beat_t                push_beat_o
);
  import wam_pkg::*;

  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [SAMPLE_W-1:0] mag;
  logic                accept;

  always_comb begin
    in_ready_o   = push_ready_i && !win_i.busy;
    push_valid_o = in_valid_i && !win_i.busy;
    accept       = in_valid_i && in_ready_o;
    mag          = sample_value_i[SAMPLE_W-1] ? (~sample_value_i + SAMPLE_W'(1))
                                              : sample_value_i;
    push_beat_o.hit   = !win_i.empty && (pos_q >= win_i.first) && (pos_q < win_i.stop)
                        && (mag <= LEVEL_LIMIT);
    push_beat_o.last  = last_sample_i;
    push_beat_o.level = mag[LEVEL_W-1:0];
    pos_d = pos_q;
    if (accept) begin
      if (last_sample_i) begin
        pos_d = '0;
      end else if (pos_q != {IDX_W{1'b1}}) begin
        pos_d = pos_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: rtl/wam_fifo.sv
module wam_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  wam_pkg::beat_t  push_beat_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output wam_pkg::beat_t  pop_beat_o
);
  import wam_pkg::*;

  beat_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop;

  always_comb begin
    push_ready_o = (cnt_q != (QPTR_W + 1)'(QUEUE_DEPTH));
    pop_valid_o  = (cnt_q != '0);
    pop_beat_o   = mem_q[rd_q];
    push         = push_valid_i && push_ready_o;
    pop          = pop_valid_o && pop_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_beat_i;
    end
  end

endmodule

// File: rtl/wam_back.sv
module wam_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  wam_pkg::beat_t               pop_beat_i,
  input  wam_pkg::window_t             win_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wam_pkg::LEVEL_W-1:0]  mean_level_o,
  output logic [wam_pkg::LEVEL_W-1:0]  rms_level_o,
  output logic [wam_pkg::LEVEL_W-1:0]  peak_level_o,
  output logic                         window_empty_o
);
  import wam_pkg::*;

  back_state_e          state_q, state_d;
  logic [ABS_W-1:0]     abs_q, abs_d;
  logic [SQ_W-1:0]      sq_q, sq_d;
  logic [LEVEL_W-1:0]   peak_q, peak_d;
  logic [SQ_W-1:0]      dvd_q, dvd_n;
  logic [IDX_W-1:0]     drem_q, drem_n;
  logic [RAD_W-1:0]     rad_q;
  logic [SREM_W-1:0]    srem_q, srem_n;
  logic [ROOT_W-1:0]    root_q, root_n;
  logic [STEP_W-1:0]    step_q;
  logic [LEVEL_W-1:0]   mean_res_q, rms_res_q;
  logic                 empty_res_q;
  logic                 out_valid_q;
  logic [LEVEL_W-1:0]   mean_out_q, rms_out_q, peak_out_q;
  logic                 empty_out_q;

  logic [IDX_W-1:0]     len;
  logic [IDX_W:0]       dtry;
  logic                 dge;
  logic [SREM_W+1:0]    stry, trial;
  logic                 sge;
  logic [2*LEVEL_W-1:0] sq_term;
  logic                 pop, emit_ok, div_end, root_end;

  always_comb begin
    pop_ready_o = (state_q == B_ACC);
    pop         = pop_valid_i && pop_ready_o;
    emit_ok     = !out_valid_q || out_ready_i;
    div_end     = (step_q == STEP_W'(SQ_W - 1));
    root_end    = (step_q == STEP_W'(ROOT_STEPS - 1));

    len    = win_i.stop - win_i.first;
    dtry   = {drem_q, dvd_q[SQ_W-1]};
    dge    = (dtry >= {1'b0, len});
    drem_n = dge ? IDX_W'(dtry - {1'b0, len}) : dtry[IDX_W-1:0];
    dvd_n  = {dvd_q[SQ_W-2:0], dge};

    stry   = {srem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    sge    = (stry >= trial);
    srem_n = sge ? SREM_W'(stry - trial) : SREM_W'(stry);
    root_n = {root_q[ROOT_W-2:0], sge};

    sq_term = pop_beat_i.level * pop_beat_i.level;
    abs_d   = abs_q;
    sq_d    = sq_q;
    peak_d  = peak_q;
    if (pop && pop_beat_i.hit) begin
      abs_d = abs_q + ABS_W'(pop_beat_i.level);
      sq_d  = sq_q + SQ_W'(sq_term);
      if (pop_beat_i.level > peak_q) begin
        peak_d = pop_beat_i.level;
      end
    end
    if (state_q == B_EMIT && emit_ok) begin
      abs_d  = '0;
      sq_d   = '0;
      peak_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_ACC: begin
        if (pop && pop_beat_i.last) begin
          state_d = win_i.empty ? B_EMIT : B_MEAN;
        end
      end
      B_MEAN: begin
        if (div_end) begin
          state_d = B_SQDIV;
        end
      end
      B_SQDIV: begin
        if (div_end) begin
          state_d = B_ROOT;
        end
      end
      B_ROOT: begin
        if (root_end) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (emit_ok) begin
          state_d = B_ACC;
        end
      end
      default: state_d = B_ACC;
    endcase
  end

  always_comb begin
    out_valid_o    = out_valid_q;
    mean_level_o   = mean_out_q;
    rms_level_o    = rms_out_q;
    peak_level_o   = peak_out_q;
    window_empty_o = empty_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_ACC;
      abs_q       <= '0;
      sq_q        <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      abs_q   <= abs_d;
      sq_q    <= sq_d;
      peak_q  <= peak_d;
      if (state_q == B_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_ACC: begin
        if (pop && pop_beat_i.last) begin
          dvd_q       <= SQ_W'(abs_d);
          drem_q      <= '0;
          step_q      <= '0;
          mean_res_q  <= '0;
          rms_res_q   <= '0;
          empty_res_q <= win_i.empty;
        end
      end
      B_MEAN: begin
        dvd_q  <= dvd_n;
        drem_q <= drem_n;
        step_q <= step_q + STEP_W'(1);
        if (div_end) begin
          mean_res_q <= dvd_n[LEVEL_W-1:0];
          dvd_q      <= sq_q;
          drem_q     <= '0;
          step_q     <= '0;
        end
      end
      B_SQDIV: begin
        dvd_q  <= dvd_n;
        drem_q <= drem_n;
        step_q <= step_q + STEP_W'(1);
        if (div_end) begin
          rad_q  <= {1'b0, dvd_n};
          srem_q <= '0;
          root_q <= '0;
          step_q <= '0;
        end
      end
      B_ROOT: begin
        rad_q  <= rad_q << 2;
        srem_q <= srem_n;
        root_q <= root_n;
        step_q <= step_q + STEP_W'(1);
        if (root_end) begin
          rms_res_q <= root_n[LEVEL_W-1:0];
        end
      end
      B_EMIT: begin
        if (emit_ok) begin
          mean_out_q  <= mean_res_q;
          rms_out_q   <= rms_res_q;
          peak_out_q  <= empty_res_q ? '0 : peak_q;
          empty_out_q <= empty_res_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/window_amplitude_meter_unit.sv
// Windowed level meter: mean, RMS and peak of a sample stream inside a time window.
// Registers (APB, 4-byte stride): sample rate, channel count, buffer size, window
// start and end time (Q15.16 seconds). A write restarts the window bound calculation;
// in_ready_o stays low while it runs.
// Input channel (valid/ready): one Q3.16 sample a beat, last_sample_i on the final
// beat of a buffer. Samples enter at one per cycle into a four-entry queue while it has
// room and no bound calculation runs; the accumulator takes one beat per cycle in B_ACC.
// Output channel (valid/ready): one result per last beat. Once the last beat leaves
// the queue, the back end runs the 57-step divider twice, then a 29-step square root,
// or goes straight to emit when the window is empty. The divide and root unit is
// iterative; the next buffer's beats queue up meanwhile.
// A result sits in the output register until taken; while the receiver stalls the
// back end holds its next result, the queue fills and in_ready_o drops.
// Reset: registers return to 44100 Hz, 2 channels, no buffer, zero times; the window
// is empty; position and accumulators are cleared.
module window_amplitude_meter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wam_pkg::ADDR_W-1:0]    paddr,
  input  logic [wam_pkg::DATA_W-1:0]    pwdata,
  output logic [wam_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wam_pkg::SAMPLE_W-1:0]  sample_value_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wam_pkg::LEVEL_W-1:0]   mean_level_o,
  output logic [wam_pkg::LEVEL_W-1:0]   rms_level_o,
  output logic [wam_pkg::LEVEL_W-1:0]   peak_level_o,
  output logic                          window_empty_o
);
  import wam_pkg::*;

  logic [RATE_W-1:0] sample_rate_q;
  logic [CH_W-1:0]   channel_count_q;
  logic [BUF_W-1:0]  buffer_samples_q;
  logic [TIME_W-1:0] start_time_q;
  logic [TIME_W-1:0] end_time_q;
  reg_index_e        cfg_index;
  logic              cfg_write;

  window_t           win;
  logic              push_valid, push_ready;
  beat_t             push_beat;
  logic              pop_valid, pop_ready;
  beat_t             pop_beat;

  always_comb begin
    pready    = 1'b1;
    cfg_index = reg_index_e'(paddr[ADDR_W-1:2]);
    cfg_write = psel && penable && pwrite && pready;
    case (cfg_index)
      REG_SAMPLE_RATE:    prdata = DATA_W'(sample_rate_q);
      REG_CHANNEL_COUNT:  prdata = DATA_W'(channel_count_q);
      REG_BUFFER_SAMPLES: prdata = DATA_W'(buffer_samples_q);
      REG_START_TIME:     prdata = DATA_W'(start_time_q);
      REG_END_TIME:       prdata = DATA_W'(end_time_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q    <= RATE_RESET;
      channel_count_q  <= CH_RESET;
      buffer_samples_q <= '0;
      start_time_q     <= '0;
      end_time_q       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLE_RATE:    sample_rate_q    <= pwdata[RATE_W-1:0];
        REG_CHANNEL_COUNT:  channel_count_q  <= pwdata[CH_W-1:0];
        REG_BUFFER_SAMPLES: buffer_samples_q <= pwdata[BUF_W-1:0];
        REG_START_TIME:     start_time_q     <= pwdata[TIME_W-1:0];
        REG_END_TIME:       end_time_q       <= pwdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wam_window u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (cfg_write),
    .sample_rate_i    (sample_rate_q),
    .channel_count_i  (channel_count_q),
    .buffer_samples_i (buffer_samples_q),
    .start_time_i     (start_time_q),
    .end_time_i       (end_time_q),
    .win_o            (win)
  );

  wam_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .last_sample_i  (last_sample_i),
    .win_i          (win),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_beat_o    (push_beat)
  );

  wam_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_beat_i  (push_beat),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_beat_o   (pop_beat)
  );

  wam_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_beat_i     (pop_beat),
    .win_i          (win),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mean_level_o   (mean_level_o),
    .rms_level_o    (rms_level_o),
    .peak_level_o   (peak_level_o),
    .window_empty_o (window_empty_o)
  );

  a_cfg_write_stalls_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> !in_ready_o
  ) else $error("input accepted while window bounds recompute");

  a_empty_result_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && window_empty_o) |->
      (mean_level_o == '0) && (rms_level_o == '0) && (peak_level_o == '0)
  ) else $error("empty window result carries nonzero levels");

  a_level_order: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (mean_level_o <= peak_level_o) && (rms_level_o <= peak_level_o) &&
      (SAMPLE_W'(peak_level_o) <= LEVEL_LIMIT)
  ) else $error("mean or rms above peak, or peak above limit");

endmodule
